### hw/rtl/dhtq_pkg.sv
// Shared types and constants for the deadline min-heap timer queue.
// Status codes, request and result field widths, and the command and status
// structs that join the controller to the datapath. Depends on nothing.
`default_nettype none

package dhtq_pkg;

   localparam int ID_W     = 5;
   localparam int TIME_W   = 48;
   localparam int IVAL_W   = 32;
   localparam int STATUS_W = 3;
   localparam int CNT_W    = 5;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_POP    = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED = 3'd0,
      STATUS_POPPED   = 3'd1,
      STATUS_NOT_DUE  = 3'd2,
      STATUS_EMPTY    = 3'd3,
      STATUS_FULL     = 3'd4
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] deadline;
   } entry_type;

   typedef struct packed {
      logic       capture;
      logic       ins_start;
      logic       pop_start;
      logic       reject;
      status_type rej_code;
      logic       pop_load;
      logic       rd_up;
      logic       move_up;
      logic       rd_kids;
      logic       move_down;
      logic       place;
   } cmd_type;

   typedef struct packed {
      logic is_pop;
      logic is_full;
      logic is_empty;
      logic not_due;
      logic up_root;
      logic up_less;
      logic dn_leaf;
      logic dn_less;
   } stat_type;

endpackage

`default_nettype wire

### hw/rtl/deadline_min_heap_timer_queue_top.sv
// Top level of the deadline min-heap timer queue.
// Instantiates dhtq_ctrl and dhtq_dp; uses dhtq_pkg.
// A request is taken when start is high and busy is low; its single result
// shows for one cycle under rsp_valid and cannot be held off. A pop first
// fetches the last entry of the heap; a sift stops at the root, at a leaf or
// on a failed compare. busy clears in the cycle after the strobe. Each level
// is a memory read followed by a compare and one write on the single write
// port of the heap memory, which sets the rate.
// Heap slots need no clearing after reset: only values read from filled slots are ever used.
`default_nettype none

module deadline_min_heap_timer_queue_top #(
   parameter int HEAP_DEPTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_func,
   input  wire logic [dhtq_pkg::ID_W-1:0]       req_task_id,
   input  wire logic [dhtq_pkg::TIME_W-1:0]     req_now_ms,
   input  wire logic [dhtq_pkg::IVAL_W-1:0]     req_refresh_ms,
   input  wire logic [dhtq_pkg::IVAL_W-1:0]     req_blink_ms,
   input  wire logic                            req_blinking,
   input  wire logic                            req_urgent_in,
   output logic                                 rsp_valid,
   output logic      [dhtq_pkg::STATUS_W-1:0]   rsp_status,
   output logic      [dhtq_pkg::ID_W-1:0]       rsp_popped_id,
   output logic      [dhtq_pkg::TIME_W-1:0]     rsp_popped_deadline,
   output logic                                 rsp_urgent_out,
   output logic      [dhtq_pkg::TIME_W-1:0]     rsp_head_deadline,
   output logic      [dhtq_pkg::CNT_W-1:0]      rsp_entry_count
);
   import dhtq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   dhtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   dhtq_dp #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_func            (req_func),
      .req_task_id         (req_task_id),
      .req_now_ms          (req_now_ms),
      .req_refresh_ms      (req_refresh_ms),
      .req_blink_ms        (req_blink_ms),
      .req_blinking        (req_blinking),
      .req_urgent_in       (req_urgent_in),
      .rsp_status          (rsp_status),
      .rsp_popped_id       (rsp_popped_id),
      .rsp_popped_deadline (rsp_popped_deadline),
      .rsp_urgent_out      (rsp_urgent_out),
      .rsp_head_deadline   (rsp_head_deadline),
      .rsp_entry_count     (rsp_entry_count)
   );

endmodule

`default_nettype wire

### hw/rtl/dhtq_ctrl.sv
// Controller state machine for the timer queue: decides insert, pop or reject and
// steps the sift loop one level per read/compare pair. Uses dhtq_pkg.
`default_nettype none

module dhtq_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire dhtq_pkg::stat_type stat,
   output dhtq_pkg::cmd_type       cmd,
   output logic                    busy,
   output logic                    rsp_valid
);
   import dhtq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_UP_CHK,
      ST_UP_CMP,
      ST_POP_LOAD,
      ST_DN_CHK,
      ST_DN_CMP,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!stat.is_pop) begin
               if (stat.is_full) begin
                  cmd.reject   = 1'b1;
                  cmd.rej_code = STATUS_FULL;
                  state_in     = ST_RESP;
               end else begin
                  cmd.ins_start = 1'b1;
                  state_in      = ST_UP_CHK;
               end
            end else if (stat.is_empty) begin
               cmd.reject   = 1'b1;
               cmd.rej_code = STATUS_EMPTY;
               state_in     = ST_RESP;
            end else if (stat.not_due) begin
               cmd.reject   = 1'b1;
               cmd.rej_code = STATUS_NOT_DUE;
               state_in     = ST_RESP;
            end else begin
               cmd.pop_start = 1'b1;
               state_in      = ST_POP_LOAD;
            end
         end
         ST_UP_CHK: begin
            if (stat.up_root) begin
               cmd.place = 1'b1;
               state_in  = ST_RESP;
            end else begin
               cmd.rd_up = 1'b1;
               state_in  = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (stat.up_less) begin
               cmd.move_up = 1'b1;
               state_in    = ST_UP_CHK;
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_RESP;
            end
         end
         ST_POP_LOAD: begin
            cmd.pop_load = 1'b1;
            state_in     = ST_DN_CHK;
         end
         ST_DN_CHK: begin
            if (stat.dn_leaf) begin
               cmd.place = 1'b1;
               state_in  = ST_RESP;
            end else begin
               cmd.rd_kids = 1'b1;
               state_in    = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            if (stat.dn_less) begin
               cmd.move_down = 1'b1;
               state_in      = ST_DN_CHK;
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in  = (state_in != ST_IDLE);
      valid_in = (state_in == ST_RESP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

### hw/rtl/dhtq_dp.sv
// Datapath for the timer queue: request capture, saturating deadline add,
// heap memory with two registered read ports, sift registers and result
// registers. Uses dhtq_pkg; driven by dhtq_ctrl.
`default_nettype none

module dhtq_dp #(
   parameter int HEAP_DEPTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire dhtq_pkg::cmd_type               cmd,
   output dhtq_pkg::stat_type                   stat,
   input  wire logic                            req_func,
   input  wire logic [dhtq_pkg::ID_W-1:0]       req_task_id,
   input  wire logic [dhtq_pkg::TIME_W-1:0]     req_now_ms,
   input  wire logic [dhtq_pkg::IVAL_W-1:0]     req_refresh_ms,
   input  wire logic [dhtq_pkg::IVAL_W-1:0]     req_blink_ms,
   input  wire logic                            req_blinking,
   input  wire logic                            req_urgent_in,
   output logic      [dhtq_pkg::STATUS_W-1:0]   rsp_status,
   output logic      [dhtq_pkg::ID_W-1:0]       rsp_popped_id,
   output logic      [dhtq_pkg::TIME_W-1:0]     rsp_popped_deadline,
   output logic                                 rsp_urgent_out,
   output logic      [dhtq_pkg::TIME_W-1:0]     rsp_head_deadline,
   output logic      [dhtq_pkg::CNT_W-1:0]      rsp_entry_count
);
   import dhtq_pkg::*;

   localparam int AW = $clog2(HEAP_DEPTH);

   entry_type mem [HEAP_DEPTH];

   logic              func_ff;
   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] now_ff;
   logic [IVAL_W-1:0] ival_ff;
   logic              urg_ff;

   logic [AW-1:0] count_ff, count_in;
   logic [AW-1:0] pos_ff, pos_in;
   entry_type     hold_ff, hold_in;
   entry_type     head_ff;
   entry_type     rd_a_ff, rd_b_ff;

   status_type        status_ff;
   logic [ID_W-1:0]   pid_ff;
   logic [TIME_W-1:0] pdl_ff;
   logic              uout_ff;

   logic [TIME_W:0]   sum;
   logic [TIME_W-1:0] new_dl;
   logic [AW-1:0]     up_idx;
   logic [AW:0]       kid_ext;
   logic [AW-1:0]     kid_idx;
   logic [AW-1:0]     rd_a_addr;
   logic [AW-1:0]     rd_b_addr;
   logic              take_right;
   entry_type         child;
   logic [AW-1:0]     child_idx;
   logic              wr_en;
   entry_type         wr_data;
   logic [AW+CNT_W-1:0] cnt_ext;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         id_ff   <= req_task_id;
         now_ff  <= req_now_ms;
         ival_ff <= req_blinking ? req_blink_ms : req_refresh_ms;
         urg_ff  <= req_urgent_in ^ req_blinking;
      end
   end

   assign sum    = {1'b0, now_ff} + {(TIME_W + 1 - IVAL_W)'(0), ival_ff};
   assign new_dl = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

   assign up_idx    = pos_ff >> 1;
   assign kid_ext   = {pos_ff, 1'b0};
   assign kid_idx   = kid_ext[AW-1:0];
   assign rd_b_addr = kid_idx + AW'(1);

   assign take_right = (kid_ext < {1'b0, count_ff}) && (rd_a_ff.deadline > rd_b_ff.deadline);
   assign child      = take_right ? rd_b_ff : rd_a_ff;
   assign child_idx  = take_right ? rd_b_addr : kid_idx;

   always_comb begin
      rd_a_addr = kid_idx;
      if (cmd.rd_up) begin
         rd_a_addr = up_idx;
      end else if (cmd.pop_start) begin
         rd_a_addr = count_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      hold_in  = hold_ff;
      if (cmd.ins_start) begin
         count_in = count_ff + AW'(1);
         pos_in   = count_ff + AW'(1);
         hold_in  = '{id: id_ff, deadline: new_dl};
      end
      if (cmd.pop_start) begin
         count_in = count_ff - AW'(1);
         pos_in   = AW'(1);
      end
      if (cmd.pop_load) begin
         hold_in = rd_a_ff;
      end
      if (cmd.move_up) begin
         pos_in = up_idx;
      end
      if (cmd.move_down) begin
         pos_in = child_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      hold_ff <= hold_in;
   end

   assign wr_en = cmd.move_up | cmd.move_down | cmd.place;

   always_comb begin
      wr_data = hold_ff;
      if (cmd.move_up) begin
         wr_data = rd_a_ff;
      end else if (cmd.move_down) begin
         wr_data = child;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[pos_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && (pos_ff == AW'(1))) begin
         head_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_start) begin
         status_ff <= STATUS_INSERTED;
         pid_ff    <= '0;
         pdl_ff    <= '0;
         uout_ff   <= urg_ff;
      end else if (cmd.pop_start) begin
         status_ff <= STATUS_POPPED;
         pid_ff    <= head_ff.id;
         pdl_ff    <= head_ff.deadline;
         uout_ff   <= 1'b0;
      end else if (cmd.reject) begin
         status_ff <= cmd.rej_code;
         pid_ff    <= '0;
         pdl_ff    <= '0;
         uout_ff   <= 1'b0;
      end
   end

   always_comb begin
      stat.is_pop   = (func_ff == FUNC_POP);
      stat.is_full  = (count_ff == AW'(HEAP_DEPTH - 1));
      stat.is_empty = (count_ff == '0);
      stat.not_due  = (head_ff.deadline > now_ff);
      stat.up_root  = (up_idx == '0);
      stat.up_less  = (hold_ff.deadline < rd_a_ff.deadline);
      stat.dn_leaf  = (kid_ext > {1'b0, count_ff});
      stat.dn_less  = (child.deadline < hold_ff.deadline);
   end

   assign cnt_ext             = {CNT_W'(0), count_ff};
   assign rsp_status          = status_ff;
   assign rsp_popped_id       = pid_ff;
   assign rsp_popped_deadline = pdl_ff;
   assign rsp_urgent_out      = uout_ff;
   assign rsp_head_deadline   = (count_ff == '0) ? '0 : head_ff.deadline;
   assign rsp_entry_count     = cnt_ext[CNT_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/dhtq_checker.sv
// Port-level checks for the timer queue top, bound to it below.
// Uses dhtq_pkg for status codes.
`default_nettype none

module dhtq_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          rsp_valid,
   input wire logic [dhtq_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [dhtq_pkg::TIME_W-1:0]   rsp_popped_deadline,
   input wire logic [dhtq_pkg::TIME_W-1:0]   rsp_head_deadline,
   input wire logic [dhtq_pkg::CNT_W-1:0]    rsp_entry_count
);
   import dhtq_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted request");

   a_strobe_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a busy window");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_EMPTY)) |->
         ((rsp_entry_count == '0) && (rsp_head_deadline == '0)))
      else $error("empty result with entries or nonzero head");

   a_pop_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_POPPED)) |->
         ((rsp_head_deadline >= rsp_popped_deadline) || (rsp_head_deadline == '0)))
      else $error("popped deadline later than new head");

endmodule

bind deadline_min_heap_timer_queue_top dhtq_checker u_dhtq_checker (.*);

`default_nettype wire
